// ===== sv/ere_pkg.sv =====
// Shared types, widths and codes for the error recovery escalator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ere_pkg;

  localparam int NUM_CATEGORIES = 16;
  localparam int CAT_W          = 4;
  localparam int LVL_W          = 2;
  localparam int RET_W          = 8;
  localparam int DLY_W          = 16;
  localparam int FAC_W          = 12;
  localparam int FRAC_W         = 8;
  localparam int ACT_W          = 2;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int NUM_LEVELS     = 4;

  localparam logic [LVL_W-1:0] LVL_STOP = 2'd3;
  localparam logic [RET_W-1:0] RET_SAT  = 8'hFF;

  localparam logic [ACT_W-1:0] ACT_REPORT  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ATTEMPT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ACT   = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DELAY,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic             active;
    logic [LVL_W-1:0] level;
    logic [RET_W-1:0] retries;
  } entry_t;

  typedef struct packed {
    logic [RET_W-1:0]      max_retries;
    logic [DLY_W-1:0]      base_delay_ms;
    logic [FAC_W-1:0]      backoff_factor;
    logic [DLY_W-1:0]      max_delay_ms;
    logic [NUM_LEVELS-1:0] level_has_action;
  } cfg_t;

  typedef struct packed {
    logic [CAT_W-1:0] category;
    logic [LVL_W-1:0] level;
    logic [RET_W-1:0] retries;
    logic             attempted;
    logic             attempt_ok;
    logic             timer_start;
    logic             stop_demand;
  } res_t;

  function automatic logic cat_in_range(input logic [CAT_W-1:0] c);
    return int'(c) < NUM_CATEGORIES;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ere_cfg.sv =====
// Configuration register file of the escalator.
// Depends on ere_pkg for widths, register indexes and cfg_t.
`default_nettype none

module ere_cfg
  import ere_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_retries      <= RET_W'(3);
      cfg.base_delay_ms    <= DLY_W'(1000);
      cfg.backoff_factor   <= FAC_W'(512);
      cfg.max_delay_ms     <= DLY_W'(30000);
      cfg.level_has_action <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_RETRIES: cfg.max_retries      <= cfg_data[RET_W-1:0];
        CFG_BASE_DELAY:  cfg.base_delay_ms    <= cfg_data[DLY_W-1:0];
        CFG_BACKOFF:     cfg.backoff_factor   <= cfg_data[FAC_W-1:0];
        CFG_MAX_DELAY:   cfg.max_delay_ms     <= cfg_data[DLY_W-1:0];
        CFG_LEVEL_ACT:   cfg.level_has_action <= cfg_data[NUM_LEVELS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ere_table.sv =====
// Per-category entry memory: one write port, one registered read port.
// Entries not written since reset read as zero through per-entry valid bits.
// Depends on ere_pkg for entry_t and the category width.
`default_nettype none

module ere_table
  import ere_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire [CAT_W-1:0]  raddr,
  output entry_t           rdata,
  input  wire              we,
  input  wire [CAT_W-1:0]  waddr,
  input  entry_t           wdata
);

  entry_t                    mem [NUM_CATEGORIES];
  logic [NUM_CATEGORIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

`default_nettype wire

// ===== sv/ere_backoff.sv =====
// Iterative backoff delay unit: one Q4.8 multiply, truncate and clamp per cycle.
// Depends on ere_pkg for widths and cfg_t.
`default_nettype none

module ere_backoff
  import ere_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              start,
  input  wire [RET_W-1:0]  count,
  input  cfg_t             cfg,
  output logic             busy,
  output logic             done,
  output logic [DLY_W-1:0] delay
);

  localparam int PROD_W = DLY_W + FAC_W;

  logic [RET_W-1:0]         cnt;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W-FRAC_W-1:0] scaled;
  logic [DLY_W-1:0]         step;
  logic [DLY_W-1:0]         first;

  assign prod   = {{FAC_W{1'b0}}, delay} * {{DLY_W{1'b0}}, cfg.backoff_factor};
  assign scaled = prod[PROD_W-1:FRAC_W];
  assign step   = (scaled > {{(PROD_W-FRAC_W-DLY_W){1'b0}}, cfg.max_delay_ms})
                ? cfg.max_delay_ms : scaled[DLY_W-1:0];
  assign first  = (cfg.base_delay_ms > cfg.max_delay_ms)
                ? cfg.max_delay_ms : cfg.base_delay_ms;
  assign done   = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      delay <= first;
      cnt   <= count;
    end else if (busy && (cnt != '0)) begin
      delay <= step;
      cnt   <= cnt - RET_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== sv/error_recovery_escalator.sv =====
// Error recovery escalator: per-category retry/escalation table with backoff.
// A request passes the execute step and then the result push; with a timer start the delay
// wait comes between them (the backoff unit does one multiply per retry, up to 254).
// One request at a time: a new one is taken only in the idle state, once the last result is loaded;
// a result waiting on out_stall holds only the output load of the next one.
// Reset (rst, synchronous): entries inactive at level 0, pending category 0, registers at defaults.
`default_nettype none

module error_recovery_escalator
  import ere_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire [ACT_W-1:0]      action,
  input  wire [CAT_W-1:0]      category,
  input  wire                  action_ok,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [CAT_W-1:0]     entry_category,
  output logic [LVL_W-1:0]     level,
  output logic [RET_W-1:0]     retries,
  output logic                 attempted,
  output logic                 attempt_ok,
  output logic                 timer_start,
  output logic [DLY_W-1:0]     delay_ms,
  output logic                 stop_demand,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  state_t            state;
  state_t            state_next;
  logic [CAT_W-1:0]  pending;
  logic [ACT_W-1:0]  req_action;
  logic [CAT_W-1:0]  req_cat;
  logic              req_ok;
  logic              in_acc;
  logic [CAT_W-1:0]  raddr;
  entry_t            rd_entry;
  logic              tbl_we;
  entry_t            ex_wdata;
  logic              ex_we;
  res_t              ex_res;
  res_t              res;
  logic [DLY_W-1:0]  res_delay;
  logic              bk_start;
  logic              bk_busy;
  logic              bk_done;
  logic [DLY_W-1:0]  bk_delay;
  logic              push;
  logic              load_out;

  ere_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Attempts act on the pending category; look it up instead of the input.
  assign in_acc = in_valid && !in_stall;
  assign raddr  = (action == ACT_ATTEMPT) ? pending : category;

  ere_table u_table (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .rdata (rd_entry),
    .we    (tbl_we),
    .waddr (req_cat),
    .wdata (ex_wdata)
  );

  ere_backoff u_backoff (
    .clk   (clk),
    .rst   (rst),
    .start (bk_start),
    .count (ex_res.retries),
    .cfg   (cfg),
    .busy  (bk_busy),
    .done  (bk_done),
    .delay (bk_delay)
  );

  // Read-modify-write of the looked-up entry.
  always_comb begin
    logic [LVL_W-1:0] l;
    logic [RET_W-1:0] r;
    logic             in_rng;
    l        = rd_entry.level;
    r        = rd_entry.retries;
    in_rng   = cat_in_range(req_cat);
    ex_we    = 1'b0;
    ex_wdata = '0;
    ex_res   = '0;
    ex_res.category = req_cat;
    case (req_action)
      ACT_REPORT: begin
        if (in_rng) begin
          if (!rd_entry.active) begin
            l = '0;
            r = '0;
          end
          if (r >= cfg.max_retries) begin
            if (l != LVL_STOP) l = l + LVL_W'(1);
            r = '0;
          end
          if (l == LVL_STOP) ex_res.stop_demand = 1'b1;
          else               ex_res.timer_start = 1'b1;
          ex_we          = 1'b1;
          ex_wdata       = '{active: 1'b1, level: l, retries: r};
          ex_res.level   = l;
          ex_res.retries = r;
        end
      end
      ACT_ATTEMPT: begin
        if (in_rng && rd_entry.active) begin
          ex_res.attempted = 1'b1;
          ex_we = 1'b1;
          if (r != RET_SAT) r = r + RET_W'(1);
          if (!cfg.level_has_action[l]) begin
            ex_wdata = '{active: 1'b1, level: l, retries: r};
          end else if (req_ok) begin
            ex_res.attempt_ok = 1'b1;
            ex_wdata = '0;
          end else begin
            if (r >= cfg.max_retries) begin
              if (l != LVL_STOP) l = l + LVL_W'(1);
              r = '0;
            end
            if (l == LVL_STOP) ex_res.stop_demand = 1'b1;
            else               ex_res.timer_start = 1'b1;
            ex_wdata = '{active: 1'b1, level: l, retries: r};
          end
          ex_res.level   = l;
          ex_res.retries = r;
        end
      end
      ACT_CLEAR: begin
        if (in_rng) begin
          ex_we    = 1'b1;
          ex_wdata = '0;
        end
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_acc) state_next = S_EXEC;
      S_EXEC:  state_next = ex_res.timer_start ? S_DELAY : S_PUSH;
      S_DELAY: if (bk_done) state_next = S_PUSH;
      S_PUSH:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall = 1'b1;
    tbl_we   = 1'b0;
    bk_start = 1'b0;
    push     = 1'b0;
    case (state)
      S_IDLE:  in_stall = 1'b0;
      S_EXEC: begin
        tbl_we   = ex_we;
        bk_start = ex_res.timer_start;
      end
      S_DELAY: ;
      S_PUSH:  push = 1'b1;
      default: ;
    endcase
  end

  assign load_out = push && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= '0;
    end else begin
      state <= state_next;
      if (state == S_EXEC && req_action == ACT_REPORT && ex_res.timer_start) begin
        pending <= req_cat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_action <= action;
      req_cat    <= raddr;
      req_ok     <= action_ok;
    end
    if (state == S_EXEC) begin
      res       <= ex_res;
      res_delay <= '0;
    end else if (state == S_DELAY && bk_done) begin
      res_delay <= bk_delay;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      entry_category <= res.category;
      level          <= res.level;
      retries        <= res.retries;
      attempted      <= res.attempted;
      attempt_ok     <= res.attempt_ok;
      timer_start    <= res.timer_start;
      delay_ms       <= res_delay;
      stop_demand    <= res.stop_demand;
    end
  end

`ifndef SYNTHESIS
  a_we_in_exec: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> state == S_EXEC)
    else $error("entry write outside the execute step");

  a_backoff_in_delay: assert property (@(posedge clk) disable iff (rst)
    bk_busy |-> state == S_DELAY)
    else $error("backoff unit busy outside the delay wait");

  a_push_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && out_valid && out_stall) |=> state == S_PUSH)
    else $error("result dropped while the output is stalled");

  a_stop_xor_timer: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(timer_start && stop_demand))
    else $error("timer start and stop demand in one result");
`endif

endmodule

`default_nettype wire
